>>> src/analog_key_axis_curve_socd_top_macros.svh
// assertion macros for the analog key axis curve and socd block
// included by the rtl files that carry concurrent checks
`ifndef ANALOG_KEY_AXIS_CURVE_SOCD_TOP_MACROS_SVH
`define ANALOG_KEY_AXIS_CURVE_SOCD_TOP_MACROS_SVH

`ifndef SYNTH
// check sampled on clk, off while reset is low
`define AKC_ASSERT_RST(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// check sampled on clk, also during reset
`define AKC_ASSERT(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define AKC_ASSERT_RST(lbl, clk, rstn, prop, msg)
`define AKC_ASSERT(lbl, clk, prop, msg)
`endif

`endif

>>> src/akc_pkg.sv
// types and constants for the analog key axis curve and socd block
// no dependencies
package akc_pkg;

    localparam int FRACTION_BITS = 12;
    localparam int PT_W          = 13;
    localparam int CFG_W         = 4 * PT_W;
    localparam int CFG_IDX_W     = 2;
    localparam int DIV_STEPS     = 7;
    localparam int CNT_W         = 3;

    localparam logic [PT_W-1:0] ONE         = PT_W'(1 << FRACTION_BITS);
    localparam logic [PT_W-1:0] PRESS_LEVEL = PT_W'(((1 << FRACTION_BITS) + 5) / 10);
    localparam logic [PT_W-1:0] ZERO_LEVEL  = PT_W'((1 << FRACTION_BITS) / 10000);
    localparam logic [PT_W-1:0] EQUAL_BAND  = PT_W'(((1 << FRACTION_BITS) * 2) / 1000);

    localparam logic [CFG_W-1:0] CURVE_RESET = 52'd17587891077120;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CURVE_X = 2'd0,
        REG_CURVE_Y = 2'd1,
        REG_INVERT  = 2'd2,
        REG_SNAPPY  = 2'd3
    } cfg_reg_t;

    typedef enum logic [1:0] {
        DIR_UNKNOWN = 2'd0,
        DIR_MINUS   = 2'd1,
        DIR_PLUS    = 2'd2
    } dir_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEL,
        ST_MUL,
        ST_DIV,
        ST_FIN,
        ST_RES,
        ST_SCALE
    } state_t;

endpackage

>>> src/analog_key_axis_curve_socd_top.sv
// analog key axis block: deadzone, three segment response curve, socd resolution
// depends on akc_pkg and analog_key_axis_curve_socd_top_macros.svh
//
// usage
// s_axis carries one item per axis update: axis, minus key level, plus key
// level. m_axis returns one signed 16-bit stick value per item, in order.
// the cfg port writes curve_x_points, curve_y_points, invert_input and
// snappy_enable by index; write it only while no item is in flight.
// each level goes through one shared multiplier and one radix-4 divider:
// select segment, multiply, divide and finish, in that order.
// a level that falls outside x0..x3 or on a zero-width segment skips the
// multiply and divide. socd resolution and scaling follow as separate steps.
// an item is taken only in idle, so s_axis_tready is low from accept until
// the result leaves the scale step for the output register; no new item is
// taken while one is in flight.
// the output register holds a result while m_axis_tready is low; the next
// item can be accepted meanwhile and waits in the scale step for the slot.
// reset clears the registers to their reset curve, the per-axis key history
// and the output valid flag.
`include "analog_key_axis_curve_socd_top_macros.svh"

module analog_key_axis_curve_socd_top
    import akc_pkg::*;
#(
    parameter int AXIS_COUNT = 4
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [31:0]          s_axis_tdata,  // axis[1:0], minus_level[14:2], plus_level[27:15]
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [15:0]          m_axis_tdata,  // stick_value[15:0]
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int IDX_W = (AXIS_COUNT > 1) ? $clog2(AXIS_COUNT) : 1;

    // configuration
    logic [CFG_W-1:0] x_pts_reg;
    logic [CFG_W-1:0] y_pts_reg;
    logic             invert_reg;
    logic             snappy_reg;

    // per-axis key history
    logic prev_m_reg [AXIS_COUNT];
    logic prev_p_reg [AXIS_COUNT];
    dir_t last_dir_reg [AXIS_COUNT];

    // sequencer and datapath
    state_t state_reg, state_next;
    logic [1:0]       axis_reg;
    logic [PT_W-1:0]  minus_reg;
    logic [PT_W-1:0]  plus_reg;
    logic             lvl_reg;
    logic [PT_W-1:0]  ya_reg;
    logic signed [PT_W:0] dy_reg;
    logic [PT_W-1:0]  n_reg;
    logic [PT_W-1:0]  d_reg;
    logic             neg_reg;
    logic [PT_W:0]    rem_reg;
    logic [PT_W:0]    num_reg;
    logic [PT_W:0]    q_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [PT_W-1:0]  mv_reg;
    logic [PT_W-1:0]  pv_reg;
    logic signed [PT_W:0] v_reg;
    logic             out_valid_reg;
    logic [15:0]      out_data_reg;

    // control from the output block
    logic in_take;
    logic out_load;

    // segment selection
    logic [PT_W-1:0] px [4];
    logic [PT_W-1:0] py [4];
    logic [PT_W-1:0] raw_lvl, x_sat, x_val;
    logic [PT_W-1:0] xa, ya, xb, yb;
    logic signed [PT_W:0] d_s, n_s, dy_s;
    logic            sel_direct;
    logic [PT_W-1:0] sel_y;

    // multiply
    logic signed [2*PT_W+1:0] prod;
    logic [2*PT_W+1:0]        prod_mag;

    // divider step
    logic [PT_W:0] r1, r2;
    logic          q1, q2;

    // finish
    logic signed [PT_W+2:0] fin_sum;
    logic [PT_W-1:0]        fin_y;

    // resolve
    logic [IDX_W-1:0] idx;
    logic             axis_ok;
    logic             use_snappy;
    logic             mdown, pdown;
    dir_t             dir_new;
    logic [PT_W-1:0]  mx;
    logic signed [PT_W:0] diff;
    logic signed [PT_W:0] res_v;

    // scaling
    logic [PT_W-1:0] mag;
    logic [29:0]     scaled;
    logic [15:0]     s_mag;

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            px[k] = x_pts_reg[PT_W*k +: PT_W];
            py[k] = y_pts_reg[PT_W*k +: PT_W];
        end
    end

    // segment selection and shortcuts
    always_comb
    begin
        raw_lvl = lvl_reg ? plus_reg : minus_reg;
        x_sat   = (raw_lvl > ONE) ? ONE : raw_lvl;
        x_val   = invert_reg ? (ONE - x_sat) : x_sat;
        if (x_val <= px[1])
        begin
            xa = px[0]; ya = py[0]; xb = px[1]; yb = py[1];
        end
        else if (x_val <= px[2])
        begin
            xa = px[1]; ya = py[1]; xb = px[2]; yb = py[2];
        end
        else
        begin
            xa = px[2]; ya = py[2]; xb = px[3]; yb = py[3];
        end
        d_s  = $signed({1'b0, xb}) - $signed({1'b0, xa});
        n_s  = $signed({1'b0, x_val}) - $signed({1'b0, xa});
        dy_s = $signed({1'b0, yb}) - $signed({1'b0, ya});
        if (d_s < 0)
        begin
            d_s = -d_s;
            n_s = -n_s;
        end
        if (n_s < 0)
            n_s = '0;
        else if (n_s > d_s)
            n_s = d_s;
        sel_direct = 1'b0;
        sel_y      = '0;
        if (x_val < px[0])
        begin
            sel_direct = 1'b1;
            sel_y      = '0;
        end
        else if (x_val > px[3])
        begin
            sel_direct = 1'b1;
            sel_y      = (py[3] > ONE) ? ONE : py[3];
        end
        else if (d_s == 0)
        begin
            sel_direct = 1'b1;
            sel_y      = (yb > ONE) ? ONE : yb;
        end
    end

    // shared multiplier
    always_comb
    begin
        prod     = dy_reg * $signed({1'b0, n_reg});
        prod_mag = prod[2*PT_W+1] ? 28'(-prod) : 28'(prod);
    end

    // two restoring steps per cycle
    always_comb
    begin
        r1 = {rem_reg[PT_W-1:0], num_reg[PT_W]};
        q1 = (r1 >= {1'b0, d_reg});
        if (q1)
            r1 = r1 - {1'b0, d_reg};
        r2 = {r1[PT_W-1:0], num_reg[PT_W-1]};
        q2 = (r2 >= {1'b0, d_reg});
        if (q2)
            r2 = r2 - {1'b0, d_reg};
    end

    always_comb
    begin
        fin_sum = $signed({3'b000, ya_reg})
                + (neg_reg ? -$signed({2'b00, q_reg}) : $signed({2'b00, q_reg}));
        if (fin_sum < 0)
            fin_y = '0;
        else if (fin_sum > $signed({3'b000, ONE}))
            fin_y = ONE;
        else
            fin_y = fin_sum[PT_W-1:0];
    end

    // socd resolution
    always_comb
    begin
        idx        = IDX_W'(axis_reg);
        axis_ok    = int'(axis_reg) < AXIS_COUNT;
        use_snappy = snappy_reg && axis_ok;
        mdown      = mv_reg >= PRESS_LEVEL;
        pdown      = pv_reg >= PRESS_LEVEL;
        dir_new    = last_dir_reg[idx];
        if (mdown && !prev_m_reg[idx])
            dir_new = DIR_MINUS;
        if (pdown && !prev_p_reg[idx])
            dir_new = DIR_PLUS;
        mx   = (mv_reg > pv_reg) ? mv_reg : pv_reg;
        diff = $signed({1'b0, pv_reg}) - $signed({1'b0, mv_reg});
        if (!use_snappy)
            res_v = diff;
        else if (mx <= ZERO_LEVEL)
            res_v = '0;
        else if (diff > $signed({1'b0, EQUAL_BAND}))
            res_v = $signed({1'b0, mx});
        else if (diff < -$signed({1'b0, EQUAL_BAND}))
            res_v = -$signed({1'b0, mx});
        else
        begin
            case (dir_new)
                DIR_PLUS:  res_v = $signed({1'b0, mx});
                DIR_MINUS: res_v = -$signed({1'b0, mx});
                default:   res_v = '0;
            endcase
        end
    end

    // scale to stick range, round half away from zero
    always_comb
    begin
        mag    = v_reg[PT_W] ? PT_W'(-v_reg) : v_reg[PT_W-1:0];
        scaled = ({mag, 17'd0} >> 1) - {16'd0, mag, 1'b0} + 30'(ONE);
        s_mag  = scaled[FRACTION_BITS+1 +: 16];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (in_take)
                    state_next = ST_SEL;
            ST_SEL:
                if (!sel_direct)
                    state_next = ST_MUL;
                else if (lvl_reg)
                    state_next = ST_RES;
            ST_MUL:
                state_next = ST_DIV;
            ST_DIV:
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                    state_next = ST_FIN;
            ST_FIN:
                state_next = lvl_reg ? ST_RES : ST_SEL;
            ST_RES:
                state_next = ST_SCALE;
            ST_SCALE:
                if (out_load)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        s_axis_tready = (state_reg == ST_IDLE);
        in_take       = s_axis_tready && s_axis_tvalid;
        out_load      = (state_reg == ST_SCALE) && (!out_valid_reg || m_axis_tready);
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_pts_reg  <= CURVE_RESET;
            y_pts_reg  <= CURVE_RESET;
            invert_reg <= 1'b0;
            snappy_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_CURVE_X: x_pts_reg  <= cfg_data;
                REG_CURVE_Y: y_pts_reg  <= cfg_data;
                REG_INVERT:  invert_reg <= cfg_data[0];
                REG_SNAPPY:  snappy_reg <= cfg_data[0];
                default:     x_pts_reg  <= x_pts_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            lvl_reg       <= 1'b0;
            cnt_reg       <= '0;
            for (int i = 0; i < AXIS_COUNT; i++)
            begin
                prev_m_reg[i]   <= 1'b0;
                prev_p_reg[i]   <= 1'b0;
                last_dir_reg[i] <= DIR_UNKNOWN;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                    lvl_reg <= 1'b0;
                ST_SEL:
                    if (sel_direct)
                        lvl_reg <= 1'b1;
                ST_MUL:
                    cnt_reg <= '0;
                ST_DIV:
                    cnt_reg <= cnt_reg + 1'b1;
                ST_FIN:
                    lvl_reg <= 1'b1;
                ST_RES:
                    if (use_snappy)
                    begin
                        prev_m_reg[idx]   <= mdown;
                        prev_p_reg[idx]   <= pdown;
                        last_dir_reg[idx] <= dir_new;
                    end
                default:
                    cnt_reg <= cnt_reg;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            axis_reg  <= s_axis_tdata[1:0];
            minus_reg <= s_axis_tdata[14:2];
            plus_reg  <= s_axis_tdata[27:15];
        end
        if (state_reg == ST_SEL)
        begin
            ya_reg <= ya;
            dy_reg <= dy_s;
            n_reg  <= n_s[PT_W-1:0];
            d_reg  <= d_s[PT_W-1:0];
            if (sel_direct)
            begin
                if (lvl_reg)
                    pv_reg <= sel_y;
                else
                    mv_reg <= sel_y;
            end
        end
        if (state_reg == ST_MUL)
        begin
            neg_reg <= prod[2*PT_W+1];
            rem_reg <= {2'b00, prod_mag[2*PT_W-1:PT_W+1]};
            num_reg <= prod_mag[PT_W:0];
            q_reg   <= '0;
        end
        if (state_reg == ST_DIV)
        begin
            rem_reg <= r2;
            num_reg <= {num_reg[PT_W-2:0], 2'b00};
            q_reg   <= {q_reg[PT_W-2:0], q1, q2};
        end
        if (state_reg == ST_FIN)
        begin
            if (lvl_reg)
                pv_reg <= fin_y;
            else
                mv_reg <= fin_y;
        end
        if (state_reg == ST_RES)
            v_reg <= res_v;
        if (out_load)
            out_data_reg <= v_reg[PT_W] ? -s_mag : s_mag;
    end

    `AKC_ASSERT_RST(a_busy_after_take, clk, rst_n, (in_take |=> !s_axis_tready), "ready high right after an accepted item")
    `AKC_ASSERT_RST(a_quot_range, clk, rst_n, ((state_reg == ST_FIN) |-> (q_reg[PT_W] == 1'b0)), "quotient exceeds the point range")
    `AKC_ASSERT_RST(a_levels_range, clk, rst_n, ((state_reg == ST_RES) |-> ((mv_reg <= ONE) && (pv_reg <= ONE))), "shaped level above full travel")
    `AKC_ASSERT_RST(a_stick_range, clk, rst_n, (m_axis_tvalid |-> (m_axis_tdata != 16'h8000)), "stick value out of range")

endmodule

>>> test/tb_analog_key_axis_curve_socd_top.sv
// testbench for analog_key_axis_curve_socd_top: curve shaping, inversion and socd stick values
// predicts every stick value in a local model and checks results in order
// depends on akc_pkg and the rtl of analog_key_axis_curve_socd_top
module tb_analog_key_axis_curve_socd_top
    import akc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int     LIMIT_CYCLES    = 500000;
    localparam int     HOLD_CYCLES     = 400;
    localparam int     ITEMS_PER_PHASE = 135;
    localparam longint UNIT            = ONE;
    localparam longint PRESS_AT        = PRESS_LEVEL;
    localparam longint ZERO_AT         = ZERO_LEVEL;
    localparam longint BAND            = EQUAL_BAND;

    typedef struct {
        logic [1:0]  axis;
        logic [15:0] stick;
    } stick_item_t;

    logic                 clk;
    logic                 rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [31:0]          s_axis_tdata;   // axis[1:0], minus_level[14:2], plus_level[27:15]
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [15:0]          m_axis_tdata;   // stick_value[15:0]
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    logic [CFG_W-1:0] curve_x;
    logic [CFG_W-1:0] curve_y;
    logic             invert_on;
    logic             snappy_on;
    logic             minus_was_down [4];
    logic             plus_was_down [4];
    dir_t             last_press [4];

    stick_item_t stick_queue [$];
    int          mismatches;
    int          items_sent;
    int          results_seen;
    int          settings_used;
    int          cycle_count;
    int          calm_left;
    bit          idle_on;
    bit          hold_request;

    analog_key_axis_curve_socd_top uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint clamp_unit(longint v);
        if (v < 0)
            return 0;
        if (v > UNIT)
            return UNIT;
        return v;
    endfunction

    function automatic longint shape_level(logic [12:0] raw);
        longint px [4];
        longint py [4];
        longint x, xa, ya, xb, yb, n, d;
        for (int k = 0; k < 4; k++)
        begin
            px[k] = curve_x[13*k +: 13];
            py[k] = curve_y[13*k +: 13];
        end
        x = clamp_unit(longint'(raw));
        if (invert_on)
            x = UNIT - x;
        if (x < px[0])
            return 0;
        if (x > px[3])
            return clamp_unit(py[3]);
        if (x <= px[1])
        begin
            xa = px[0]; ya = py[0]; xb = px[1]; yb = py[1];
        end
        else if (x <= px[2])
        begin
            xa = px[1]; ya = py[1]; xb = px[2]; yb = py[2];
        end
        else
        begin
            xa = px[2]; ya = py[2]; xb = px[3]; yb = py[3];
        end
        d = xb - xa;
        if (d == 0)
            return clamp_unit(yb);
        n = x - xa;
        if (d < 0)
        begin
            d = -d;
            n = -n;
        end
        if (n < 0)
            n = 0;
        if (n > d)
            n = d;
        return clamp_unit(ya + ((yb - ya) * n) / d);
    endfunction

    // last press wins when the two keys are close
    function automatic longint resolve_socd(logic [1:0] axis, longint mv, longint pv);
        logic   mdown;
        logic   pdown;
        longint peak;
        longint diff;
        mdown = (mv >= PRESS_AT);
        pdown = (pv >= PRESS_AT);
        if (mdown && !minus_was_down[axis])
            last_press[axis] = DIR_MINUS;
        if (pdown && !plus_was_down[axis])
            last_press[axis] = DIR_PLUS;
        minus_was_down[axis] = mdown;
        plus_was_down[axis]  = pdown;
        peak = (mv > pv) ? mv : pv;
        if (peak <= ZERO_AT)
            return 0;
        diff = pv - mv;
        if (diff > BAND)
            return peak;
        if (diff < -BAND)
            return -peak;
        if (last_press[axis] == DIR_PLUS)
            return peak;
        if (last_press[axis] == DIR_MINUS)
            return -peak;
        return 0;
    endfunction

    function automatic logic [15:0] predict_stick(logic [1:0] axis, logic [12:0] ml,
                                                  logic [12:0] pl);
        longint mv, pv, v, mag, s;
        mv = shape_level(ml);
        pv = shape_level(pl);
        if (snappy_on)
            v = resolve_socd(axis, mv, pv);
        else
            v = pv - mv;
        if (v > UNIT)
            v = UNIT;
        if (v < -UNIT)
            v = -UNIT;
        mag = (v < 0) ? -v : v;
        s = (mag * 65534 + UNIT) / (2 * UNIT);
        if (v < 0)
            s = -s;
        return s[15:0];
    endfunction

    task automatic reset_model();
        curve_x   = CURVE_RESET;
        curve_y   = CURVE_RESET;
        invert_on = 1'b0;
        snappy_on = 1'b0;
        for (int i = 0; i < 4; i++)
        begin
            minus_was_down[i] = 1'b0;
            plus_was_down[i]  = 1'b0;
            last_press[i]     = DIR_UNKNOWN;
        end
    endtask

    function automatic logic [CFG_W-1:0] pack_points(int p0, int p1, int p2, int p3);
        return {13'(p3), 13'(p2), 13'(p1), 13'(p0)};
    endfunction

    function automatic logic [CFG_W-1:0] ordered_points();
        int p [4];
        int t;
        for (int i = 0; i < 4; i++)
            p[i] = $urandom_range(0, 4096);
        if ($urandom_range(0, 3) == 0)
            p[2] = p[1];
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3 - i; j++)
                if (p[j] > p[j+1])
                begin
                    t = p[j];
                    p[j] = p[j+1];
                    p[j+1] = t;
                end
        return pack_points(p[0], p[1], p[2], p[3]);
    endfunction

    function automatic logic [CFG_W-1:0] any_points();
        return {20'($urandom), $urandom};
    endfunction

    function automatic logic [12:0] pick_level();
        case ($urandom_range(0, 15))
            0:       return 13'd0;
            1:       return 13'd4096;
            2, 3:    return 13'($urandom_range(400, 420));
            4, 5:    return 13'($urandom_range(0, 409));
            6:       return 13'($urandom_range(4097, 8191));
            default: return 13'($urandom_range(0, 4096));
        endcase
    endfunction

    function automatic logic [12:0] near_level(logic [12:0] lvl);
        int v;
        v = int'(lvl) + int'($urandom_range(0, 20)) - 10;
        if (v < 0)
            v = 0;
        if (v > 4096)
            v = 4096;
        return 13'(v);
    endfunction

    task automatic send_item(logic [1:0] axis, logic [12:0] ml, logic [12:0] pl);
        int gap;
        if (calm_left > 0)
            calm_left--;
        else if (idle_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 12);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        else if ($urandom_range(0, 9) == 0)
            calm_left = $urandom_range(5, 30);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, pl, ml, axis};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        stick_queue.push_back('{axis: axis, stick: predict_stick(axis, ml, pl)});
        items_sent++;
    endtask

    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        while (stick_queue.size() != 0)
            @(posedge clk);
    endtask

    task automatic configure(logic [CFG_W-1:0] xs, logic [CFG_W-1:0] ys, logic inv,
                             logic snap);
        wait_for_results();
        cfg_we    <= 1'b1;
        cfg_index <= REG_CURVE_X;
        cfg_data  <= xs;
        @(posedge clk);
        cfg_index <= REG_CURVE_Y;
        cfg_data  <= ys;
        @(posedge clk);
        cfg_index <= REG_INVERT;
        cfg_data  <= (any_points() << 1) | CFG_W'(inv);
        @(posedge clk);
        cfg_index <= REG_SNAPPY;
        cfg_data  <= (any_points() << 1) | CFG_W'(snap);
        @(posedge clk);
        cfg_we    <= 1'b0;
        curve_x   = xs;
        curve_y   = ys;
        invert_on = inv;
        snappy_on = snap;
        settings_used++;
    endtask

    task automatic test_reset_curve();
        send_item(2'd0, 13'd0, 13'd4096);
        send_item(2'd1, 13'd4096, 13'd0);
        send_item(2'd2, 13'd8191, 13'd100);
    endtask

    task automatic test_curve_shapes();
        logic [CFG_W-1:0] linear;
        linear = pack_points(0, 1365, 2731, 4096);
        configure(linear, linear, 1'b0, 1'b0);
        send_item(2'd3, 13'd0, 13'd0);
        send_item(2'd0, 13'd4096, 13'd4096);
        send_item(2'd1, 13'd0, 13'd4096);
        send_item(2'd2, 13'd4096, 13'd0);
        send_item(2'd3, 13'd1, 13'd2);
        send_item(2'd0, 13'd5000, 13'd0);
        // deadzone below x0 and clip above x3
        configure(pack_points(200, 1000, 3000, 3900), pack_points(0, 500, 3500, 4096),
                  1'b0, 1'b0);
        send_item(2'd1, 13'd100, 13'd200);
        send_item(2'd2, 13'd1000, 13'd2999);
        send_item(2'd3, 13'd3950, 13'd0);
        // zero-width first segment, y above one
        configure(pack_points(500, 500, 2000, 3000), pack_points(0, 5000, 3000, 4096),
                  1'b0, 1'b0);
        send_item(2'd0, 13'd500, 13'd501);
        send_item(2'd1, 13'd499, 13'd2500);
    endtask

    task automatic test_invert();
        logic [CFG_W-1:0] linear;
        linear = pack_points(0, 1365, 2731, 4096);
        configure(linear, linear, 1'b1, 1'b0);
        send_item(2'd0, 13'd0, 13'd4096);
        send_item(2'd1, 13'd1000, 13'd3000);
    endtask

    task automatic test_snappy();
        logic [CFG_W-1:0] linear;
        linear = pack_points(0, 1365, 2731, 4096);
        configure(linear, linear, 1'b0, 1'b1);
        send_item(2'd0, 13'd410, 13'd0);
        send_item(2'd0, 13'd410, 13'd409);
        send_item(2'd0, 13'd2000, 13'd2000);
        send_item(2'd0, 13'd2000, 13'd2008);
        send_item(2'd0, 13'd1000, 13'd1009);
        send_item(2'd1, 13'd2000, 13'd2000);
        send_item(2'd2, 13'd500, 13'd500);
        send_item(2'd3, 13'd0, 13'd0);
    endtask

    task automatic test_backpressure();
        hold_request = 1'b1;
        repeat (20)
            send_item(2'($urandom), pick_level(), pick_level());
        wait_for_results();
    endtask

    task automatic send_random_item();
        logic [1:0]  axis;
        logic [12:0] ml;
        logic [12:0] pl;
        axis = 2'($urandom);
        ml   = pick_level();
        case ($urandom_range(0, 3))
            0:       pl = near_level(ml);
            1:       pl = 13'($urandom_range(0, 300));
            default: pl = pick_level();
        endcase
        if ($urandom_range(0, 1) == 1)
            send_item(axis, ml, pl);
        else
            send_item(axis, pl, ml);
    endtask

    task automatic test_random();
        logic [CFG_W-1:0] linear;
        linear = pack_points(0, 1365, 2731, 4096);
        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase)
                0: configure(linear, linear, 1'b0, 1'b1);
                1: configure(pack_points(200, 1000, 3000, 3900),
                             pack_points(0, 500, 3500, 4096), 1'b1, 1'b1);
                2: configure(ordered_points(), any_points(), 1'($urandom), 1'($urandom));
                3: configure('0, '0, 1'b0, 1'b0);
                4: configure('1, '1, 1'b1, 1'b1);
                5: configure(any_points(), any_points(), 1'($urandom), 1'($urandom));
                6: configure(ordered_points(), ordered_points(), 1'($urandom), 1'b1);
                default:
                begin
                    configure(linear, ordered_points(), 1'b0, 1'b1);
                    idle_on = 1'b0;
                end
            endcase
            repeat (ITEMS_PER_PHASE)
                send_random_item();
        end
    endtask

    initial
    begin : receiver
        int span;
        m_axis_tready <= 1'b0;
        forever
        begin
            if (hold_request)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                m_axis_tready <= 1'b0;
                span = $urandom_range(1, 12);
                repeat (span) @(posedge clk);
            end
            else
            begin
                m_axis_tready <= 1'b1;
                span = $urandom_range(1, 16);
                repeat (span) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin : check_results
        stick_item_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            results_seen++;
            if (stick_queue.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected stick value %0d", $signed(m_axis_tdata));
            end
            else
            begin
                want = stick_queue.pop_front();
                if (m_axis_tdata !== want.stick)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("axis %0d stick_value expected %0d got %0d", want.axis,
                                 $signed(want.stick), $signed(m_axis_tdata));
                end
            end
        end
    end

    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        mismatches    = 0;
        items_sent    = 0;
        results_seen  = 0;
        settings_used = 1;
        calm_left     = 0;
        idle_on       = 1'b1;
        hold_request  = 1'b0;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        cfg_we        <= 1'b0;
        cfg_index     <= REG_CURVE_X;
        cfg_data      <= '0;
        reset_model();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_curve();
        test_curve_shapes();
        test_invert();
        test_snappy();
        test_backpressure();
        test_random();
        wait_for_results();
        repeat (30) @(posedge clk);
        $display("sent %0d items and checked %0d stick values over %0d curve settings",
                 items_sent, results_seen, settings_used);
        $display("covered deadzone, clipping, zero-width segments, inversion, socd and stalls");
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+src
src/akc_pkg.sv
src/analog_key_axis_curve_socd_top.sv
test/tb_analog_key_axis_curve_socd_top.sv
